// ===== rtl/ptwmv_pkg.sv =====
// ---------------------------------------------------------------------------
// Per-track window majority vote: shared definitions
// Sizes, register indexes and the per-track bookkeeping record.
// ---------------------------------------------------------------------------
`default_nettype none

package ptwmv_pkg;

    localparam int NUM_TRACKS = 64;
    localparam int MAX_WINDOW = 16;
    localparam int MAX_LEVELS = 8;

    localparam int TRK_W      = $clog2(NUM_TRACKS);
    localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W      = WIN_W;
    localparam int LVL_W      = 3;
    localparam int WL_W       = 5;
    localparam int NL_W       = 4;
    localparam int VOTE_DEPTH = NUM_TRACKS * MAX_WINDOW;
    localparam int VOTE_AW    = TRK_W + PTR_W;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_LEVELS    = 2'd1;

    localparam logic [WL_W-1:0] WL_RESET = 5'd8;
    localparam logic [NL_W-1:0] NL_RESET = 4'd5;

    // Write pointer and fill count of one track, kept in a small memory.
    typedef struct packed {
        logic [WIN_W-1:0] fill;
        logic [PTR_W-1:0] wp;
    } t_meta;

    localparam int META_W = $bits(t_meta);

endpackage

`default_nettype wire

// ===== rtl/ptwmv_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ptwmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/per_track_window_majority_vote_top.sv =====
// ---------------------------------------------------------------------------
// Per-track window majority vote
// Keeps a ring of recent level predictions per track and returns the
// most frequent level in the ring after each new prediction.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_stall) carries a track slot and a predicted
// level. The output channel (o_valid / i_stall) returns one voted level for
// every input transaction, in order. Registers window_length and num_levels
// are written through i_cfg_we / i_cfg_addr / i_cfg_data while the block is
// idle.
// After acceptance a transaction passes through META, SCAN, DRAIN, ARGMAX
// and FINISH. SCAN reads fill ring entries, where fill is the track's ring
// occupancy after the update (at most the effective window length). The ring
// memory is scanned one entry per cycle, then a single comparator walks the
// effective num_levels level counters one per cycle. No new transaction is
// accepted until the current one has left FINISH.
// o_stall is low only in the idle state. A result waiting on a stalled
// receiver does not block acceptance of the next transaction; that one is
// processed and then holds in its final state until the output is free.
// Reset clears the per-track seen bits, so every track restarts empty, and
// loads the register defaults (window 8, levels 5). No clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module per_track_window_majority_vote_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ptwmv_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [ptwmv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [5:0]                          i_track_slot,
    input  wire logic [2:0]                          i_predicted_level,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic      [2:0]                          o_voted_level
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_META   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_ARGMAX = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [ptwmv_pkg::WL_W-1:0]  r_wl;
    logic [ptwmv_pkg::NL_W-1:0]  r_nl;

    logic [ptwmv_pkg::TRK_W-1:0] r_slot;
    logic [ptwmv_pkg::LVL_W-1:0] r_level;
    logic [ptwmv_pkg::WIN_W-1:0] r_fill;
    logic [ptwmv_pkg::WIN_W-1:0] r_idx;
    logic                        r_rd_pend;
    logic [ptwmv_pkg::CNT_W-1:0] r_cnt [ptwmv_pkg::MAX_LEVELS];
    logic [ptwmv_pkg::LVL_W-1:0] r_k;
    logic [ptwmv_pkg::LVL_W-1:0] r_best;
    logic [ptwmv_pkg::CNT_W-1:0] r_bestc;
    logic [ptwmv_pkg::NUM_TRACKS-1:0] r_seen;
    logic                        r_out_valid;
    logic [ptwmv_pkg::LVL_W-1:0] r_out_level;

    logic [ptwmv_pkg::WIN_W-1:0] win;
    logic [ptwmv_pkg::NL_W-1:0]  lev;
    logic [ptwmv_pkg::LVL_W-1:0] lev_m1;
    logic [ptwmv_pkg::LVL_W-1:0] lvl_in;
    logic                        in_accept;
    logic                        out_free;

    ptwmv_pkg::t_meta            meta_q;
    ptwmv_pkg::t_meta            meta_new;
    logic [ptwmv_pkg::META_W-1:0] meta_rdata;
    logic [ptwmv_pkg::PTR_W-1:0] wp_old;
    logic [ptwmv_pkg::WIN_W-1:0] wp_inc;
    logic [ptwmv_pkg::WIN_W-1:0] fill_old;

    logic [ptwmv_pkg::LVL_W-1:0] vote_rdata;
    logic [ptwmv_pkg::LVL_W-1:0] vote_v;
    logic                        is_meta;
    logic                        cmp_gt;

    // Effective register values.
    always_comb begin
        if (r_wl == '0) begin
            win = ptwmv_pkg::WIN_W'(1);
        end else if (r_wl > ptwmv_pkg::WL_W'(ptwmv_pkg::MAX_WINDOW)) begin
            win = ptwmv_pkg::WIN_W'(ptwmv_pkg::MAX_WINDOW);
        end else begin
            win = ptwmv_pkg::WIN_W'(r_wl);
        end
        if (r_nl == '0) begin
            lev = ptwmv_pkg::NL_W'(1);
        end else if (r_nl > ptwmv_pkg::NL_W'(ptwmv_pkg::MAX_LEVELS)) begin
            lev = ptwmv_pkg::NL_W'(ptwmv_pkg::MAX_LEVELS);
        end else begin
            lev = r_nl;
        end
    end

    assign lev_m1    = ptwmv_pkg::LVL_W'(lev - ptwmv_pkg::NL_W'(1));
    assign lvl_in    = (i_predicted_level > lev_m1) ? lev_m1 : i_predicted_level;
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign is_meta   = (r_state == S_META);

    // Track bookkeeping: an unseen track reads as empty.
    assign meta_q = ptwmv_pkg::t_meta'(meta_rdata);

    always_comb begin
        wp_old   = r_seen[r_slot] ? meta_q.wp : '0;
        fill_old = r_seen[r_slot] ? meta_q.fill : '0;
        // A pointer left beyond a shrunken window restarts at the front.
        if (ptwmv_pkg::WIN_W'(wp_old) >= win) begin
            wp_old = '0;
        end
        if (fill_old > win) begin
            fill_old = win;
        end
        wp_inc = ptwmv_pkg::WIN_W'(wp_old) + ptwmv_pkg::WIN_W'(1);
        meta_new.wp   = (wp_inc == win) ? '0 : wp_inc[ptwmv_pkg::PTR_W-1:0];
        meta_new.fill = (fill_old < win) ? fill_old + ptwmv_pkg::WIN_W'(1) : fill_old;
    end

    ptwmv_ram #(
        .WIDTH (ptwmv_pkg::META_W),
        .DEPTH (ptwmv_pkg::NUM_TRACKS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (is_meta),
        .i_waddr (r_slot),
        .i_wdata (meta_new),
        .i_raddr (i_track_slot[ptwmv_pkg::TRK_W-1:0]),
        .o_rdata (meta_rdata)
    );

    ptwmv_ram #(
        .WIDTH (ptwmv_pkg::LVL_W),
        .DEPTH (ptwmv_pkg::VOTE_DEPTH)
    ) u_vote_ram (
        .i_clk   (i_clk),
        .i_we    (is_meta),
        .i_waddr ({r_slot, wp_old}),
        .i_wdata (r_level),
        .i_raddr ({r_slot, r_idx[ptwmv_pkg::PTR_W-1:0]}),
        .o_rdata (vote_rdata)
    );

    // Stored levels above the current limit are counted at the limit.
    assign vote_v = (vote_rdata > lev_m1) ? lev_m1 : vote_rdata;
    assign cmp_gt = (r_cnt[r_k] > r_bestc);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == r_fill - ptwmv_pkg::WIN_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_ARGMAX;
            end
            S_ARGMAX: begin
                if (r_k == lev_m1) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wl        <= ptwmv_pkg::WL_RESET;
            r_nl        <= ptwmv_pkg::NL_RESET;
            r_seen      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_SCAN);

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ptwmv_pkg::REG_WINDOW_LENGTH: r_wl <= i_cfg_data[ptwmv_pkg::WL_W-1:0];
                    ptwmv_pkg::REG_NUM_LEVELS:    r_nl <= i_cfg_data[ptwmv_pkg::NL_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (is_meta) begin
                r_seen[r_slot] <= 1'b1;
            end

            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_slot  <= i_track_slot[ptwmv_pkg::TRK_W-1:0];
            r_level <= lvl_in;
        end

        if (is_meta) begin
            r_fill  <= meta_new.fill;
            r_idx   <= '0;
            r_k     <= '0;
            r_best  <= '0;
            r_bestc <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + ptwmv_pkg::WIN_W'(1);
        end

        for (int k = 0; k < ptwmv_pkg::MAX_LEVELS; k++) begin
            if (is_meta) begin
                r_cnt[k] <= '0;
            end else if (r_rd_pend && (vote_v == ptwmv_pkg::LVL_W'(k))) begin
                r_cnt[k] <= r_cnt[k] + ptwmv_pkg::CNT_W'(1);
            end
        end

        // One comparison per cycle; strict greater keeps the lowest level on ties.
        if (r_state == S_ARGMAX) begin
            r_k <= r_k + ptwmv_pkg::LVL_W'(1);
            if (cmp_gt) begin
                r_best  <= r_k;
                r_bestc <= r_cnt[r_k];
            end
        end

        if ((r_state == S_FINISH) && out_free) begin
            r_out_level <= r_best;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_voted_level = r_out_level;

    a_scan_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_fill != '0 && r_fill <= win))
        else $error("scan fill count out of window range");

    a_scan_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_fill))
        else $error("scan index beyond fill count");

    a_level_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META) |-> (r_level <= lev_m1))
        else $error("stored level exceeds level limit");

    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> (r_best <= lev_m1))
        else $error("voted level exceeds level limit");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the per-track window majority vote
// Sends level predictions for many tracks across several register settings.
// The settings include out-of-range window and level counts. A scoreboard
// class keeps its own copy of every track's ring and predicts each voted
// level in order. Both channels idle at random.
// ---------------------------------------------------------------------------

module tb_top;

    import ptwmv_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_PHASES = 8;

    class vote_scoreboard;
        logic [WL_W-1:0]  window_reg;
        logic [NL_W-1:0]  levels_reg;
        logic [LVL_W-1:0] ring [VOTE_DEPTH];
        bit               ring_written [VOTE_DEPTH];
        int unsigned      ring_ptr [NUM_TRACKS];
        int unsigned      ring_fill [NUM_TRACKS];
        bit               track_seen [NUM_TRACKS];
        logic [LVL_W-1:0] expected_votes [$];
        int               errors;

        function new();
            window_reg = WL_RESET;
            levels_reg = NL_RESET;
            errors = 0;
        endfunction

        function void take_regs(logic [WL_W-1:0] wl, logic [NL_W-1:0] nl);
            window_reg = wl;
            levels_reg = nl;
        endfunction

        function int unsigned window_span();
            if (window_reg == 0) return 1;
            if (window_reg > MAX_WINDOW) return MAX_WINDOW;
            return window_reg;
        endfunction

        function int unsigned level_span();
            if (levels_reg == 0) return 1;
            if (levels_reg > MAX_LEVELS) return MAX_LEVELS;
            return levels_reg;
        endfunction

        // A track is usable only if its next vote reads no ring entry that
        // was never written; that can happen after the window grows.
        function bit slot_is_open(logic [TRK_W-1:0] slot);
            int unsigned span, wp, cnt, base, i;
            span = window_span();
            base = slot * MAX_WINDOW;
            wp = track_seen[slot] ? ring_ptr[slot] : 0;
            cnt = track_seen[slot] ? ring_fill[slot] : 0;
            if (wp >= span) wp = 0;
            if (cnt > span) cnt = span;
            if (cnt < span) cnt++;
            for (i = 0; i < cnt; i++) begin
                if (i != wp && !ring_written[base + i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void predict_vote(logic [TRK_W-1:0] slot, logic [LVL_W-1:0] lvl);
            int unsigned span, lev, base, wp, cnt, v, i, best, best_cnt;
            int unsigned tally [MAX_LEVELS];
            span = window_span();
            lev = level_span();
            base = slot * MAX_WINDOW;
            if (!track_seen[slot]) begin
                track_seen[slot] = 1'b1;
                ring_ptr[slot] = 0;
                ring_fill[slot] = 0;
            end
            v = lvl;
            if (v > lev - 1) v = lev - 1;
            wp = ring_ptr[slot];
            if (wp >= span) wp = 0;
            ring[base + wp] = LVL_W'(v);
            ring_written[base + wp] = 1'b1;
            ring_ptr[slot] = (wp + 1) % span;
            cnt = ring_fill[slot];
            if (cnt > span) cnt = span;
            if (cnt < span) cnt++;
            ring_fill[slot] = cnt;
            for (i = 0; i < MAX_LEVELS; i++) tally[i] = 0;
            // Entries stored under a larger level count are clamped here.
            for (i = 0; i < cnt; i++) begin
                v = ring[base + i];
                if (v > lev - 1) v = lev - 1;
                tally[v]++;
            end
            best = 0;
            best_cnt = tally[0];
            for (i = 1; i < lev; i++) begin
                if (tally[i] > best_cnt) begin
                    best_cnt = tally[i];
                    best = i;
                end
            end
            expected_votes = {expected_votes, LVL_W'(best)};
        endfunction

        function void check_vote(logic [LVL_W-1:0] got);
            logic [LVL_W-1:0] want;
            if (expected_votes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] voted level %0d with no transaction pending",
                             $time, got);
                return;
            end
            want = expected_votes.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] voted level: expected %0d, got %0d",
                             $time, want, got);
            end
        endfunction

        function int pending();
            return expected_votes.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [TRK_W-1:0]      i_track_slot = '0;
    logic [LVL_W-1:0]      i_predicted_level = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [LVL_W-1:0]      o_voted_level;

    vote_scoreboard sb;
    int cycles = 0;
    bit send_quiet = 1'b0;
    int send_quiet_left = 0;
    bit rx_quiet = 1'b0;
    int rx_quiet_left = 0;
    int rx_hold = 0;

    int window_plan [NUM_PHASES] = '{16, 16, 4, 0, 1, 31, 7, 12};
    int levels_plan [NUM_PHASES] = '{8, 3, 8, 0, 15, 9, 1, 6};
    int picks_plan [NUM_PHASES] = '{300, 160, 160, 120, 120, 180, 160, 180};

    per_track_window_majority_vote_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_track_slot      (i_track_slot),
        .i_predicted_level (i_predicted_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_voted_level     (o_voted_level)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (send_quiet_left == 0) begin
            send_quiet = !send_quiet;
            send_quiet_left = $urandom_range(20, 120);
        end else begin
            send_quiet_left--;
        end
        if (send_quiet || $urandom_range(0, 2) != 0) return 0;
        return pause_len();
    endfunction

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall && sb != null)
            sb.check_vote(o_voted_level);
        if (rx_quiet_left == 0) begin
            rx_quiet = !rx_quiet;
            rx_quiet_left = $urandom_range(30, 300);
        end else begin
            rx_quiet_left--;
        end
        if (rx_hold > 0)
            rx_hold--;
        else if (!rx_quiet && $urandom_range(0, 2) == 0)
            rx_hold = pause_len();
        i_stall <= (rx_hold > 0);
    end

    // Valid stays high between back-to-back transactions; it only drops
    // when a gap is taken or the block is being reprogrammed.
    task automatic push_pick(input logic [TRK_W-1:0] slot, input logic [LVL_W-1:0] lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_track_slot <= slot;
        i_predicted_level <= lvl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.predict_vote(slot, lvl);
    endtask

    task automatic program_regs(input logic [WL_W-1:0] wl, input logic [NL_W-1:0] nl);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || o_stall);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_WINDOW_LENGTH;
        i_cfg_data <= CFG_DATA_W'(wl);
        @(posedge i_clk);
        i_cfg_addr <= REG_NUM_LEVELS;
        i_cfg_data <= CFG_DATA_W'(nl);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.take_regs(wl, nl);
    endtask

    function automatic bit find_open_track(output logic [TRK_W-1:0] slot);
        int start, k;
        start = $urandom_range(0, NUM_TRACKS - 1);
        for (k = 0; k < NUM_TRACKS; k++) begin
            slot = TRK_W'((start + k) % NUM_TRACKS);
            if (sb.slot_is_open(slot)) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Bursts of predictions to one track, with a favored level so that the
    // vote has a real majority, mixed with single stray predictions.
    task automatic run_phase(input int target);
        int sent, tries, burst, n;
        logic [TRK_W-1:0] slot;
        logic [LVL_W-1:0] fav, lvl;
        sent = 0;
        tries = 0;
        while (sent < target && tries < target * 4) begin
            tries++;
            burst = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(2, 24);
            fav = LVL_W'($urandom_range(0, 7));
            if (find_open_track(slot)) begin
                for (n = 0; n < burst && sent < target; n++) begin
                    if (!sb.slot_is_open(slot)) break;
                    lvl = $urandom_range(0, 1) ? fav : LVL_W'($urandom_range(0, 7));
                    push_pick(slot, lvl);
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        int k, phase;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first sight, a level above the limit, ties going
        // to the lower level, and a ring that wraps past its window.
        push_pick(6'd0, 3'd0);
        push_pick(6'd63, 3'd7);
        push_pick(6'd63, 3'd1);
        push_pick(6'd63, 3'd4);
        push_pick(6'd63, 3'd1);
        for (k = 0; k < 10; k++) push_pick(6'd42, LVL_W'(k % 3 + 2));
        push_pick(6'd21, 3'd6);
        push_pick(6'd21, 3'd5);
        push_pick(6'd0, 3'd3);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            program_regs(WL_W'(window_plan[phase]), NL_W'(levels_plan[phase]));
            run_phase(picks_plan[phase]);
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
